// ----- design/gtc_pkg.sv -----
// Shared types, constants and microcode encodings for the glyph text console.
// Used by every console core module except gtc_ram; depends on nothing else.
`default_nettype none
package gtc_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(GLYPH_ROWS);
  localparam int UPC_W       = 4;

  localparam logic [12:0] CELL_W     = 13'd8;
  localparam logic [16:0] LINE_H     = 17'd16;
  localparam logic [16:0] Y_MAX      = 17'd65535;
  localparam logic [7:0]  FULL_MASK  = 8'hFF;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_BS   = 2'd1,
    OP_NL   = 2'd2,
    OP_LOAD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_SCREEN_WIDTH = 3'd0,
    CFG_LINE_PITCH   = 3'd1,
    CFG_BASE_ADDRESS = 3'd2,
    CFG_FG_COLOR     = 3'd3,
    CFG_BG_COLOR     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [3:0] glyph_row;
    logic [7:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [47:0] row_address;
    logic [7:0]  pixel_mask;
    logic [31:0] pixel_color;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [13:0] line_pitch;
    logic [47:0] base_address;
    logic [31:0] fg_color;
    logic [31:0] bg_clear_color;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_GOTO,
    SEQ_DISPATCH,
    SEQ_EMIT
  } seq_t;

  typedef struct packed {
    seq_t             seq;
    logic [UPC_W-1:0] target;
    logic             do_mul;
    logic             col_back;
    logic             ld_addr;
    logic             mask_full;
    logic             bs_fix;
    logic             cur_put;
    logic             cur_bs;
    logic             cur_nl;
    logic             font_wr;
  } ctrl_word_t;

  typedef struct packed {
    logic slot_free;
    logic row_last;
  } dp_status_t;

  // Microcode addresses.
  localparam logic [UPC_W-1:0] UA_FETCH    = 4'd0;
  localparam logic [UPC_W-1:0] UA_PUT_MUL  = 4'd1;
  localparam logic [UPC_W-1:0] UA_PUT_ADDR = 4'd2;
  localparam logic [UPC_W-1:0] UA_PUT_EMIT = 4'd3;
  localparam logic [UPC_W-1:0] UA_PUT_CUR  = 4'd4;
  localparam logic [UPC_W-1:0] UA_BS_FIX   = 4'd5;
  localparam logic [UPC_W-1:0] UA_BS_MUL   = 4'd6;
  localparam logic [UPC_W-1:0] UA_BS_ADDR  = 4'd7;
  localparam logic [UPC_W-1:0] UA_BS_EMIT  = 4'd8;
  localparam logic [UPC_W-1:0] UA_BS_CUR   = 4'd9;
  localparam logic [UPC_W-1:0] UA_NL       = 4'd10;
  localparam logic [UPC_W-1:0] UA_LOAD     = 4'd11;

endpackage
`default_nettype wire

// ----- design/glyph_text_console_renderer_core.sv -----
// Glyph text console core: put character, backspace, newline and font load.
// A put steps through multiply, address load, an emit loop of one row per cycle while
// the output is not stalled, and cursor update; a backspace adds a cursor fix step
// first; newline and font load are a single step each. No new item is taken until fetch.
// Reset (synchronous, rst_n low): cursor at 0,0, registers at defaults, font store
// contents unchanged and undefined until loaded.
`default_nettype none
module glyph_text_console_renderer_core
  import gtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  cfg_regs_t  cfg_r;
  ctrl_word_t ctrl;
  dp_status_t status;
  logic       accept;
  logic       emit;

  assign in_stall = (ctrl.seq != SEQ_DISPATCH);
  assign accept   = in_valid && !in_stall;
  assign emit     = (ctrl.seq == SEQ_EMIT) && status.slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width   <= 13'd640;
      cfg_r.line_pitch     <= 14'd640;
      cfg_r.base_address   <= 48'd0;
      cfg_r.fg_color       <= 32'hFFFF_FFFF;
      cfg_r.bg_clear_color <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCREEN_WIDTH: cfg_r.screen_width   <= cfg_data[12:0];
        CFG_LINE_PITCH:   cfg_r.line_pitch     <= cfg_data[13:0];
        CFG_BASE_ADDRESS: cfg_r.base_address   <= cfg_data;
        CFG_FG_COLOR:     cfg_r.fg_color       <= cfg_data[31:0];
        CFG_BG_COLOR:     cfg_r.bg_clear_color <= cfg_data[31:0];
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  gtc_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .status   (status),
    .ctrl     (ctrl)
  );

  gtc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .accept    (accept),
    .in_item   (in_data),
    .cfg       (cfg_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

`ifndef SYNTHESIS
  // An accepted transaction always leaves the fetch step.
  a_accept_leaves_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (ctrl.seq != SEQ_DISPATCH))
    else $error("sequencer stayed in fetch after accepting a transaction");

  // The emit loop ends right after the sixteenth row write.
  a_emit_loop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && status.row_last) |=> (ctrl.seq != SEQ_EMIT))
    else $error("emit loop ran past the last row");

  // The output register is only filled by an emit step.
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(emit))
    else $error("output became valid without an emit step");

  // Font writes and row writes never share a cycle.
  a_no_write_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.font_wr && (ctrl.seq == SEQ_EMIT)))
    else $error("font write issued during the emit loop");
`endif

endmodule
`default_nettype wire

// ----- design/gtc_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package dependencies.
`default_nettype none
module gtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/gtc_useq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
// Depends on gtc_pkg for the control word layout and microcode addresses.
`default_nettype none
module gtc_useq
  import gtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire op_t        in_op,
  input  wire dp_status_t status,
  output ctrl_word_t      ctrl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;

  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_word_t w;
    w = '0;
    w.seq    = SEQ_GOTO;
    w.target = UA_FETCH;
    unique case (addr)
      UA_FETCH:    w.seq = SEQ_DISPATCH;
      UA_PUT_MUL:  begin w.seq = SEQ_NEXT; w.do_mul = 1'b1; end
      UA_PUT_ADDR: begin w.seq = SEQ_NEXT; w.ld_addr = 1'b1; end
      UA_PUT_EMIT: w.seq = SEQ_EMIT;
      UA_PUT_CUR:  w.cur_put = 1'b1;
      UA_BS_FIX:   begin w.seq = SEQ_NEXT; w.bs_fix = 1'b1; end
      UA_BS_MUL:   begin w.seq = SEQ_NEXT; w.do_mul = 1'b1; w.col_back = 1'b1; end
      UA_BS_ADDR:  begin w.seq = SEQ_NEXT; w.ld_addr = 1'b1; end
      UA_BS_EMIT:  begin w.seq = SEQ_EMIT; w.mask_full = 1'b1; end
      UA_BS_CUR:   w.cur_bs = 1'b1;
      UA_NL:       w.cur_nl = 1'b1;
      UA_LOAD:     w.font_wr = 1'b1;
      default:     w.seq = SEQ_GOTO;
    endcase
    return w;
  endfunction

  assign ctrl = ucode(upc_r);

  always_comb begin
    upc_nxt = upc_r;
    unique case (ctrl.seq)
      SEQ_NEXT: upc_nxt = upc_r + 1'b1;
      SEQ_GOTO: upc_nxt = ctrl.target;
      SEQ_DISPATCH: begin
        if (in_valid) begin
          unique case (in_op)
            OP_PUT:  upc_nxt = UA_PUT_MUL;
            OP_BS:   upc_nxt = UA_BS_FIX;
            OP_NL:   upc_nxt = UA_NL;
            OP_LOAD: upc_nxt = UA_LOAD;
          endcase
        end
      end
      SEQ_EMIT: begin
        if (status.slot_free && status.row_last) begin
          upc_nxt = upc_r + 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/gtc_datapath.sv -----
// Console datapath: cursor, address arithmetic, font store and output register.
// Depends on gtc_pkg and gtc_ram; driven by the control word of gtc_useq.
`default_nettype none
module gtc_datapath
  import gtc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ctrl_word_t ctrl,
  input  wire logic       accept,
  input  wire in_item_t   in_item,
  input  wire cfg_regs_t  cfg,
  input  wire logic       out_stall,
  output logic            out_valid,
  output out_item_t       out_data,
  output dp_status_t      status
);

  logic [7:0]       code_r;
  logic [3:0]       grow_r;
  logic [7:0]       bits_r;
  logic [12:0]      x_r, x_nxt;
  logic [15:0]      y_r, y_nxt;
  logic [12:0]      col_r;
  logic [29:0]      prod_r;
  logic [47:0]      addr_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic [7:0]       font_byte;
  logic             emit;
  logic [16:0]      y_down, y_up;
  logic [12:0]      col_back;
  logic [30:0]      cell_index;

  assign status.slot_free = !out_valid_r || !out_stall;
  assign status.row_last  = (row_r == ROW_W'(GLYPH_ROWS - 1));
  assign emit = (ctrl.seq == SEQ_EMIT) && status.slot_free;

  always_comb begin
    y_down = {1'b0, y_r} + LINE_H;
    if (y_down > Y_MAX) begin
      y_down = Y_MAX;
    end
    y_up = ({1'b0, y_r} >= LINE_H) ? ({1'b0, y_r} - LINE_H) : 17'd0;
    col_back = (x_r >= CELL_W) ? (x_r - CELL_W) : 13'd0;
    cell_index = {1'b0, prod_r} + {18'd0, col_r};
  end

  always_comb begin
    row_nxt = row_r;
    if (accept) begin
      row_nxt = '0;
    end else if (emit) begin
      row_nxt = row_r + 1'b1;
    end
  end

  // The read address follows the next row, so the font byte for the current
  // row is already registered when the emit step reaches it.
  gtc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ctrl.font_wr),
    .waddr ({code_r, grow_r}),
    .wdata (bits_r),
    .raddr ({code_r, row_nxt}),
    .rdata (font_byte)
  );

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctrl.bs_fix && (x_r == 13'd0)) begin
      x_nxt = cfg.screen_width;
      y_nxt = y_up[15:0];
    end
    if (ctrl.cur_put) begin
      // Wrap when the cell after this one would not fit on the line.
      if ({1'b0, x_r} + {1'b0, CELL_W} + {1'b0, CELL_W} > {1'b0, cfg.screen_width}) begin
        x_nxt = 13'd0;
        y_nxt = y_down[15:0];
      end else begin
        x_nxt = x_r + CELL_W;
      end
    end
    if (ctrl.cur_bs) begin
      x_nxt = col_r;
    end
    if (ctrl.cur_nl) begin
      x_nxt = 13'd0;
      y_nxt = y_down[15:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_r <= in_item.char_code;
      grow_r <= in_item.glyph_row;
      bits_r <= in_item.glyph_bits;
    end
    if (ctrl.do_mul) begin
      prod_r <= {14'd0, y_r} * {16'd0, cfg.line_pitch};
      col_r  <= ctrl.col_back ? col_back : x_r;
    end
    if (ctrl.ld_addr) begin
      addr_r <= cfg.base_address + {15'd0, cell_index, 2'b00};
    end else if (emit) begin
      addr_r <= addr_r + {32'd0, cfg.line_pitch, 2'b00};
    end
    if (emit) begin
      out_data_r.row_address <= addr_r;
      out_data_r.pixel_mask  <= ctrl.mask_full ? FULL_MASK : font_byte;
      out_data_r.pixel_color <= ctrl.mask_full ? cfg.bg_clear_color : cfg.fg_color;
      out_data_r.last_row    <= status.row_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- sim/gtc_row_write_checker.sv -----
// Checker for the glyph text console core: shadows its font store, cursor and
// registers, predicts every framebuffer row write and compares them in order.
// Depends on gtc_pkg for the transaction, register index and opcode types.
module gtc_row_write_checker
  import gtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          rows_pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_regs_t   regs;
  logic [7:0]  font_shadow [STORE_DEPTH];
  logic [12:0] cur_x;
  logic [15:0] cur_y;
  out_item_t   pending_row_writes [$];

  initial begin
    rows_pending = 0;
    fail_count   = 0;
  end

  // The cursor row saturates instead of wrapping when it moves down.
  function automatic logic [15:0] line_below(logic [15:0] y);
    return (y >= 16'd65520) ? 16'hFFFF : y + 16'd16;
  endfunction

  function automatic logic [15:0] line_above(logic [15:0] y);
    return (y >= 16'd16) ? y - 16'd16 : 16'd0;
  endfunction

  function automatic logic [47:0] fb_row_address(int unsigned col, int unsigned row);
    logic [63:0] offs;
    logic [63:0] addr;
    offs = 64'(col) + 64'(row) * 64'(regs.line_pitch);
    addr = {16'd0, regs.base_address} + (offs << 2);
    return addr[47:0];
  endfunction

  task automatic predict_console_op(in_item_t it);
    out_item_t   row_wr;
    int unsigned col;
    case (it.op)
      OP_PUT: begin
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          row_wr.row_address = fb_row_address(cur_x, cur_y + r);
          row_wr.pixel_mask  = font_shadow[{it.char_code, 4'(r)}];
          row_wr.pixel_color = regs.fg_color;
          row_wr.last_row    = (r == GLYPH_ROWS - 1);
          pending_row_writes.push_back(row_wr);
        end
        if (32'(cur_x) + 32'd16 > 32'(regs.screen_width)) begin
          cur_x = 13'd0;
          cur_y = line_below(cur_y);
        end else begin
          cur_x = cur_x + CELL_W;
        end
      end
      OP_BS: begin
        // At the start of a line the erase targets the last cell of the line above.
        if (cur_x == 13'd0) begin
          cur_x = regs.screen_width;
          cur_y = line_above(cur_y);
        end
        col = (cur_x >= CELL_W) ? cur_x - CELL_W : 0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
          row_wr.row_address = fb_row_address(col, cur_y + r);
          row_wr.pixel_mask  = FULL_MASK;
          row_wr.pixel_color = regs.bg_clear_color;
          row_wr.last_row    = (r == GLYPH_ROWS - 1);
          pending_row_writes.push_back(row_wr);
        end
        cur_x = 13'(col);
      end
      OP_NL: begin
        cur_x = 13'd0;
        cur_y = line_below(cur_y);
      end
      OP_LOAD: font_shadow[{it.char_code, it.glyph_row}] = it.glyph_bits;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      regs.screen_width   = 13'd640;
      regs.line_pitch     = 14'd640;
      regs.base_address   = 48'd0;
      regs.fg_color       = 32'hFFFF_FFFF;
      regs.bg_clear_color = 32'd0;
      cur_x = 13'd0;
      cur_y = 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SCREEN_WIDTH: regs.screen_width   = cfg_data[12:0];
          CFG_LINE_PITCH:   regs.line_pitch     = cfg_data[13:0];
          CFG_BASE_ADDRESS: regs.base_address   = cfg_data;
          CFG_FG_COLOR:     regs.fg_color       = cfg_data[31:0];
          CFG_BG_COLOR:     regs.bg_clear_color = cfg_data[31:0];
          default: ;
        endcase
      end
      // Outputs are checked before this edge's input transaction is predicted,
      // since a row write can never belong to an item accepted at the same edge.
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_row_writes.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected row write addr=%h mask=%h color=%h last=%b", $realtime,
                     out_data.row_address, out_data.pixel_mask, out_data.pixel_color,
                     out_data.last_row);
          fail_count++;
        end else begin
          want = pending_row_writes.pop_front();
          if (out_data.row_address !== want.row_address ||
              out_data.pixel_mask  !== want.pixel_mask  ||
              out_data.pixel_color !== want.pixel_color ||
              out_data.last_row    !== want.last_row) begin
            if (fail_count < 10)
              $display("%0t: row write mismatch: expected addr=%h mask=%h color=%h last=%b, got addr=%h mask=%h color=%h last=%b",
                       $realtime, want.row_address, want.pixel_mask, want.pixel_color,
                       want.last_row, out_data.row_address, out_data.pixel_mask,
                       out_data.pixel_color, out_data.last_row);
            fail_count++;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        predict_console_op(in_data);
    end
    rows_pending = pending_row_writes.size();
  end

endmodule

// ----- sim/tb_glyph_text_console_renderer_core.sv -----
// Testbench top for the glyph text console core: clock, reset, register setup
// and console transactions under several pacing modes, plus the final verdict.
// Depends on gtc_pkg, the core itself and gtc_row_write_checker.
module tb_glyph_text_console_renderer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gtc_pkg::*;

  typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_data   = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data  = '0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int rows_pending;
  int fail_count;
  int items_sent     = 0;

  // Tracks which font bytes have been loaded so that a character is only drawn
  // once all sixteen rows of its glyph are defined.
  bit         font_written   [STORE_DEPTH];
  bit         glyph_is_ready [256];
  logic [7:0] ready_glyphs   [$];

  always #4 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < sink_stall_pct);

  glyph_text_console_renderer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gtc_row_write_checker row_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rows_pending (rows_pending),
    .fail_count   (fail_count)
  );

  task automatic set_pace(pace_t p);
    src_idle_pct   = (p == PACE_SRC_IDLE)   ? 86 : (p == PACE_BOTH) ? 20 : 0;
    sink_stall_pct = (p == PACE_SINK_STALL) ? 86 : (p == PACE_BOTH) ? 20 : 0;
  endtask

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[47:0];
  endfunction

  // Sends one transaction and returns right after the edge that accepted it.
  task automatic send_console_op(op_t op, logic [7:0] code, logic [3:0] row,
                                 logic [7:0] bits);
    in_item_t it;
    bit       full;
    bit       taken;
    it.op         = op;
    it.char_code  = code;
    it.glyph_row  = row;
    it.glyph_bits = bits;
    if (op == OP_LOAD && !glyph_is_ready[code]) begin
      font_written[{code, row}] = 1'b1;
      full = 1'b1;
      for (int r = 0; r < GLYPH_ROWS; r++)
        full &= font_written[{code, 4'(r)}];
      if (full) begin
        glyph_is_ready[code] = 1'b1;
        ready_glyphs.push_back(code);
      end
    end
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // The stall is sampled mid-cycle, where it is settled for the coming edge.
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic load_glyph(logic [7:0] code);
    logic [7:0] bits;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      case (r)
        0:       bits = 8'h00;
        1:       bits = 8'hFF;
        2:       bits = 8'h80;
        3:       bits = 8'h01;
        default: bits = 8'($urandom);
      endcase
      send_console_op(OP_LOAD, code, 4'(r), bits);
    end
  endtask

  task automatic random_items(int count);
    int stop_at;
    int sel;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 40 && ready_glyphs.size() > 0)
        send_console_op(OP_PUT, ready_glyphs[$urandom_range(ready_glyphs.size() - 1)],
                        4'($urandom), 8'($urandom));
      else if (sel < 40 || (sel >= 70 && sel < 78))
        load_glyph(8'($urandom));
      else if (sel < 62)
        send_console_op(OP_BS, 8'($urandom), 4'($urandom), 8'($urandom));
      else if (sel < 70)
        send_console_op(OP_NL, 8'($urandom), 4'($urandom), 8'($urandom));
      else
        send_console_op(OP_LOAD, 8'($urandom), 4'($urandom), 8'($urandom));
    end
  endtask

  // Waits until every row write has arrived, then gives a trailing newline or
  // font load time to finish inside the core.
  task automatic drain_console();
    in_valid <= 1'b0;
    do @(negedge clk); while (rows_pending != 0);
    repeat (32) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [12:0] width, logic [13:0] pitch, logic [47:0] base,
                           logic [31:0] fg, logic [31:0] bg, pace_t pace);
    drain_console();
    write_reg(CFG_SCREEN_WIDTH, 48'(width));
    write_reg(CFG_LINE_PITCH, 48'(pitch));
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_FG_COLOR, 48'(fg));
    write_reg(CFG_BG_COLOR, 48'(bg));
    cfg_we <= 1'b0;
    set_pace(pace);
    random_items(75);
  endtask

  initial begin
    set_pace(PACE_FULL);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings: draw, erase, backspace at the top
    // left corner, wrap at the right edge, newline and backspace across a line.
    load_glyph(8'hFF);
    send_console_op(OP_PUT, 8'hFF, 4'h0, 8'h00);
    send_console_op(OP_BS, 8'h00, 4'hF, 8'hFF);
    send_console_op(OP_BS, 8'hFF, 4'h0, 8'h00);
    send_console_op(OP_PUT, 8'hFF, 4'hF, 8'hFF);
    send_console_op(OP_NL, 8'h00, 4'h0, 8'h00);
    send_console_op(OP_BS, 8'h00, 4'h0, 8'h00);
    send_console_op(OP_PUT, 8'hFF, 4'h5, 8'hA5);

    run_phase(13'd4096, 14'd8192, 48'hFFFF_FFFF_F000, $urandom, $urandom,
              PACE_SRC_IDLE);
    run_phase(13'd8, 14'd8, 48'd0, 32'd0, 32'hFFFF_FFFF, PACE_SINK_STALL);
    run_phase(13'd100, 14'($urandom_range(8, 8192)), rand48(), $urandom, $urandom,
              PACE_BOTH);
    run_phase(13'($urandom_range(8, 4096)), 14'($urandom_range(8, 8192)),
              48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd0, PACE_FULL);
    run_phase(13'($urandom_range(8, 64)), 14'($urandom_range(8, 8192)), rand48(),
              $urandom, $urandom, PACE_SRC_IDLE);
    run_phase(13'($urandom_range(8, 4096)), 14'd640, rand48(), $urandom, $urandom,
              PACE_BOTH);
    drain_console();

    if (fail_count == 0 && rows_pending == 0)
      $display("tb_glyph_text_console_renderer_core passed");
    else
      $display("tb_glyph_text_console_renderer_core failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_glyph_text_console_renderer_core failed");
    $finish;
  end

endmodule

// ----- glyph_text_console_renderer_core.f -----
design/gtc_pkg.sv
design/gtc_ram.sv
design/gtc_useq.sv
design/gtc_datapath.sv
design/glyph_text_console_renderer_core.sv
sim/gtc_row_write_checker.sv
sim/tb_glyph_text_console_renderer_core.sv
